@@ hw/rtl/fpr_pkg.sv @@
// types, constants and seed table for the fixed-point reciprocal
package fpr_pkg;

	localparam int unsigned NORM_LOW  = 3276;
	localparam int unsigned NORM_HIGH = 36044;
	localparam int unsigned SIXTH     = 5461;
	localparam logic [39:0] RECIP_MAX = 40'd2147483647;

	localparam logic [1:0] RS_OK     = 2'd0;
	localparam logic [1:0] RS_NONPOS = 2'd1;
	localparam logic [1:0] RS_SAT    = 2'd2;

	typedef logic signed [26:0] word_t;

	typedef enum logic [3:0] {
		STEP_K1,
		STEP_T2,
		STEP_K2,
		STEP_T3,
		STEP_K3,
		STEP_T4,
		STEP_K4,
		STEP_SUM,
		STEP_FIN
	} step_t;

	typedef struct packed {
		logic  load;
		logic  norm;
		logic  mul;
		logic  upd;
		logic  fin;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic nonpos;
		logic norm_done;
	} sts_t;

	localparam logic [18:0] SEED [64] = '{
		19'd327680, 19'd283398, 19'd249660, 19'd223101,
		19'd201649, 19'd183960, 19'd169125, 19'd156503,
		19'd145635, 19'd136178, 19'd127875, 19'd120525,
		19'd113975, 19'd108100, 19'd102801, 19'd97997,
		19'd93622,  19'd89621,  19'd85948,  19'd82565,
		19'd79437,  19'd76538,  19'd73843,  19'd71331,
		19'd68985,  19'd66788,  19'd64726,  19'd62788,
		19'd60963,  19'd59241,  19'd57614,  19'd56073,
		19'd54613,  19'd53227,  19'd51909,  19'd50655,
		19'd49461,  19'd48321,  19'd47233,  19'd46192,
		19'd45197,  19'd44243,  19'd43329,  19'd42452,
		19'd41610,  19'd40800,  19'd40021,  19'd39272,
		19'd38550,  19'd37854,  19'd37183,  19'd36535,
		19'd35910,  19'd35305,  19'd34721,  19'd34155,
		19'd33608,  19'd33078,  19'd32564,  19'd32066,
		19'd31583,  19'd31115,  19'd30660,  19'd30218
	};

endpackage

@@ hw/rtl/fpr_in_if.sv @@
// operand channel: valid, ready and the signed 16.15 operand
interface fpr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

@@ hw/rtl/fpr_out_if.sv @@
// result channel: valid, ready, reciprocal and status
interface fpr_out_if;
	logic        valid;
	logic        ready;
	logic [30:0] reciprocal;
	logic [1:0]  status;

	modport source (output valid, output reciprocal, output status, input ready);
	modport sink (input valid, input reciprocal, input status, output ready);
endinterface

@@ hw/rtl/fpr_dp.sv @@
// datapath: normalizer, shared multiplier, refinement registers, output register
module fpr_dp (
	input  logic            clk,
	input  fpr_pkg::cmd_t   cmd,
	input  logic [31:0]     value,
	output fpr_pkg::sts_t   sts,
	output logic [30:0]     reciprocal,
	output logic [1:0]      status
);

	logic [30:0]          x_q;
	logic signed [5:0]    sh_q;
	logic                 nonpos_q;
	fpr_pkg::word_t       k_q;
	fpr_pkg::word_t       t_q;
	fpr_pkg::word_t       sum_q;
	logic signed [53:0]   prod_s1;
	logic [30:0]          recip_q;
	logic [1:0]           status_q;

	logic [15:0]          diff;
	logic [5:0]           idx;
	fpr_pkg::word_t       y0;
	fpr_pkg::word_t       h;
	fpr_pkg::word_t       op_a;
	fpr_pkg::word_t       op_b;
	fpr_pkg::word_t       q;
	fpr_pkg::word_t       neg_q;
	logic [39:0]          mag;
	logic [39:0]          shifted;
	logic [5:0]           nsh;

	assign diff  = x_q[15:0] - 16'(fpr_pkg::NORM_LOW);
	assign idx   = diff[14:9];
	assign y0    = $signed({8'd0, fpr_pkg::SEED[idx]});
	assign h     = $signed({18'd0, diff[8:0]});
	assign q     = prod_s1[41:15];
	assign neg_q = -q;

	always_comb begin
		case (cmd.step)
			fpr_pkg::STEP_K1: begin
				op_a = y0;
				op_b = y0;
			end
			fpr_pkg::STEP_T2, fpr_pkg::STEP_T3: begin
				op_a = h;
				op_b = k_q >>> 1;
			end
			fpr_pkg::STEP_T4: begin
				op_a = h;
				op_b = k_q;
			end
			fpr_pkg::STEP_SUM: begin
				op_a = h;
				op_b = sum_q;
			end
			fpr_pkg::STEP_FIN: begin
				op_a = t_q;
				op_b = 27'(fpr_pkg::SIXTH);
			end
			default: begin
				op_a = t_q;
				op_b = t_q;
			end
		endcase
	end

	assign sts.nonpos    = nonpos_q;
	assign sts.norm_done = x_q inside
		{[31'(fpr_pkg::NORM_LOW) : 31'(fpr_pkg::NORM_HIGH - 1)]};

	assign mag = {14'd0, t_q[25:0]};
	assign nsh = -sh_q;

	always_comb begin
		if (!sh_q[5]) begin
			shifted = mag << sh_q[3:0];
		end else begin
			shifted = mag >> nsh[4:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= value[30:0];
			sh_q     <= '0;
			nonpos_q <= value[31] || (value == 32'd0);
		end
		if (cmd.norm) begin
			if (x_q >= 31'(fpr_pkg::NORM_HIGH)) begin
				x_q  <= x_q >> 1;
				sh_q <= sh_q - 6'sd1;
			end else if (x_q < 31'(fpr_pkg::NORM_LOW)) begin
				x_q  <= x_q << 1;
				sh_q <= sh_q + 6'sd1;
			end
		end
		if (cmd.mul) begin
			prod_s1 <= op_a * op_b;
		end
		if (cmd.upd) begin
			case (cmd.step)
				fpr_pkg::STEP_K1: begin
					k_q   <= neg_q;
					sum_q <= neg_q;
				end
				fpr_pkg::STEP_K2, fpr_pkg::STEP_K3: begin
					k_q   <= neg_q;
					sum_q <= sum_q + (neg_q <<< 1);
				end
				fpr_pkg::STEP_K4: begin
					sum_q <= sum_q + neg_q;
				end
				fpr_pkg::STEP_SUM: begin
					t_q <= q;
				end
				default: begin
					t_q <= y0 + q;
				end
			endcase
		end
		if (cmd.fin) begin
			if (nonpos_q) begin
				recip_q  <= '0;
				status_q <= fpr_pkg::RS_NONPOS;
			end else if (t_q < 0) begin
				recip_q  <= '0;
				status_q <= fpr_pkg::RS_SAT;
			end else if (shifted > fpr_pkg::RECIP_MAX) begin
				recip_q  <= fpr_pkg::RECIP_MAX[30:0];
				status_q <= fpr_pkg::RS_SAT;
			end else begin
				recip_q  <= shifted[30:0];
				status_q <= fpr_pkg::RS_OK;
			end
		end
	end

	assign reciprocal = recip_q;
	assign status     = status_q;

endmodule

@@ hw/rtl/fpr_ctrl.sv @@
// controller: sequences normalization, refinement steps and result handoff
module fpr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  fpr_pkg::sts_t  sts,
	output fpr_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_NORM,
		S_MUL,
		S_UPD,
		S_DONE
	} state_t;

	state_t          state_q;
	fpr_pkg::step_t  step_q;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.step = step_q;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_NORM: cmd.norm = !sts.nonpos && !sts.norm_done;
			S_MUL:  cmd.mul  = 1'b1;
			S_UPD:  cmd.upd  = 1'b1;
			S_DONE: cmd.fin  = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= fpr_pkg::STEP_K1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (sts.nonpos) begin
						state_q <= S_DONE;
					end else if (sts.norm_done) begin
						step_q  <= fpr_pkg::STEP_K1;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_UPD;
				S_UPD: begin
					if (step_q == fpr_pkg::STEP_FIN) begin
						state_q <= S_DONE;
					end else begin
						step_q  <= fpr_pkg::step_t'(4'(step_q) + 4'd1);
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_load_starts_norm: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_NORM)
		else $error("accepted transaction did not start normalization");

	a_mul_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> sts.norm_done)
		else $error("multiply step on an operand outside the normalized range");

	a_fin_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !out_valid_q || out_ready)
		else $error("result register overwritten before it was taken");

	a_fin_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid_q)
		else $error("finished result not presented");

endmodule

@@ hw/rtl/fixed_point_reciprocal.sv @@
// top level: reciprocal of a signed 16.15 operand, table seed plus one Runge-Kutta step
//
//   channel   dir   transaction payload
//   operand   in    value[31:0]       signed 16.15
//   result    out   reciprocal[30:0]  16.15, status[1:0]
//
// one transaction at a time: accept, then normalize (n shifts, up to 16), then nine steps,
// each a multiply on the one shared multiplier and then an update, then the result;
// a non-positive operand skips normalization and the multiply steps
// arst_n clears the controller and the result valid; no clearing pass
// a stalled result holds in the output register while the next operand is taken
module fixed_point_reciprocal (
	input  logic           clk,
	input  logic           arst_n,
	fpr_in_if.sink         operand,
	fpr_out_if.source      result
);

	fpr_pkg::cmd_t  cmd;
	fpr_pkg::sts_t  sts;

	fpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (operand.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fpr_dp u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.value      (operand.value),
		.sts        (sts),
		.reciprocal (result.reciprocal),
		.status     (result.status)
	);

endmodule
